// ===== hdl/bc_block_texture_decoder_core_macros.svh =====
// ---------------------------------------------------------------------------
// bc_block_texture_decoder_core_macros
// Assertion helpers shared by the block texture decoder modules. Each macro
// samples on the rising edge of clock and is disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef BC_BLOCK_TEXTURE_DECODER_CORE_MACROS_SVH
`define BC_BLOCK_TEXTURE_DECODER_CORE_MACROS_SVH

// property that holds at every edge
`define BCD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("bcd assertion failed");

// consequent in the same cycle as the antecedent
`define BCD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcd assertion failed");

// consequent in the cycle after the antecedent
`define BCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcd assertion failed");

`endif

// ===== hdl/bcd_pkg.sv =====
// ---------------------------------------------------------------------------
// bcd_pkg
// Types, constants and arithmetic helpers of the block texture decoder.
// ---------------------------------------------------------------------------
package bcd_pkg;

   // block geometry
   localparam int NUM_PIX = 16;
   localparam int PIX_W   = 4;

   // block queue between palette front end and pixel back end
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_BC_VARIANT = '0;

   // variant codes as written to the register
   localparam logic [1:0] VARIANT_BC1 = 2'd0;
   localparam logic [1:0] VARIANT_BC2 = 2'd1;
   localparam logic [1:0] VARIANT_BC3 = 2'd2;

   // color channels
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // color index that is transparent black in three-color mode
   localparam logic [1:0] TRANSPARENT_IDX = 2'd3;

   // start of the interpolated alpha indices in the alpha word
   localparam logic [5:0] ALPHA_IDX_BASE = 6'd16;

   // reciprocals for the truncating divisions
   localparam int RECIP3 = 683;
   localparam int SHIFT3 = 11;
   localparam int RECIP5 = 3277;
   localparam int RECIP7 = 2341;
   localparam int SHIFT57 = 14;

   // where the alpha of a pixel comes from
   typedef enum logic [1:0] {
      AMODE_COLOR,
      AMODE_EXPLICIT,
      AMODE_INTERP
   } alpha_mode_type;

   // one decoded block as handed from front end to back end
   typedef struct packed {
      logic [2:0][3:0][7:0] pal;         // channel, color entry
      logic                 trans3;      // entry 3 is transparent black
      logic [7:0][7:0]      apal;        // interpolated alpha palette
      logic [63:0]          alpha_word;  // explicit nibbles or alpha indices
      logic [31:0]          cidx;        // two-bit color indices
      alpha_mode_type       amode;
   } blk_type;

   // rgb565 field widening by bit replication
   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // x / 3 for x up to 765
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = {10'd0, x} * 20'(RECIP3);
      return p[SHIFT3+7:SHIFT3];
   endfunction

   // x / 5 for x up to 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = {12'd0, x} * 23'(RECIP5);
      return p[SHIFT57+7:SHIFT57];
   endfunction

   // x / 7 for x up to 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = {12'd0, x} * 23'(RECIP7);
      return p[SHIFT57+7:SHIFT57];
   endfunction

endpackage

// ===== hdl/bcd_req_if.sv =====
// ---------------------------------------------------------------------------
// bcd_req_if
// Input channel: one compressed block word pair per handshake.
// ---------------------------------------------------------------------------
interface bcd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] alpha_word;
   logic [63:0] color_word;

   modport source (output valid, output alpha_word, output color_word, input ready);
   modport sink (input valid, input alpha_word, input color_word, output ready);
endinterface

// ===== hdl/bcd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bcd_rsp_if
// Result channel: one decoded BGRA8 pixel per handshake.
// ---------------------------------------------------------------------------
interface bcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pixel_index;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, output pixel_index, output blue, output green,
                   output red, output alpha, output last_pixel, input ready);
   modport sink (input valid, input pixel_index, input blue, input green,
                 input red, input alpha, input last_pixel, output ready);
endinterface

// ===== hdl/bcd_csr.sv =====
// ---------------------------------------------------------------------------
// bcd_csr
// APB-style configuration register holding the block format.
// ---------------------------------------------------------------------------
module bcd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [1:0]                       variant
);

   logic [1:0]                       variant_ff;
   logic [1:0]                       variant_in;
   logic [bcd_pkg::CSR_IDX_W-1:0]    reg_idx;
   logic                             wr_en;

   assign reg_idx = csr_paddr[bcd_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      variant_in = variant_ff;
      if (wr_en && (reg_idx == bcd_pkg::REG_BC_VARIANT)) begin
         variant_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= bcd_pkg::VARIANT_BC1;
      end else begin
         variant_ff <= variant_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == bcd_pkg::REG_BC_VARIANT) begin
         csr_prdata = {{(bcd_pkg::CSR_DATA_W-2){1'b0}}, variant_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign variant    = variant_ff;

endmodule

// ===== hdl/bcd_front.sv =====
// ---------------------------------------------------------------------------
// bcd_front
// Front end: captures a block, classifies its format and builds the color
// and alpha palettes over a two-stage pipeline.
// ---------------------------------------------------------------------------
module bcd_front (
   input  logic              clock,
   input  logic              reset,
   bcd_req_if.sink           req_chan,
   input  logic [1:0]        variant,
   output bcd_pkg::blk_type  blk,
   output logic              blk_valid,
   input  logic              blk_ready
);

   // capture stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [63:0]             s1_aw_ff;
   logic [63:0]             s1_cw_ff;
   bcd_pkg::alpha_mode_type s1_amode_ff, s1_amode_in;

   // sum stage
   logic                    s2_valid_ff, s2_valid_in;
   logic [2:0][7:0]         s2_e0_ff, s2_e0_in;
   logic [2:0][7:0]         s2_e1_ff, s2_e1_in;
   logic [2:0][9:0]         s2_sum2_ff, s2_sum2_in;
   logic [2:0][9:0]         s2_sum3_ff, s2_sum3_in;
   logic                    s2_four_ff, s2_four_in;
   logic [7:0]              s2_a0_ff;
   logic [7:0]              s2_a1_ff;
   logic                    s2_agt_ff, s2_agt_in;
   logic [5:0][10:0]        s2_asum_ff, s2_asum_in;
   logic [63:0]             s2_aw_ff;
   logic [31:0]             s2_cidx_ff;
   bcd_pkg::alpha_mode_type s2_amode_ff;

   logic        req_take;
   logic        s2_load;
   logic        s2_adv;
   logic [15:0] c0;
   logic [15:0] c1;
   logic [7:0]  a0;
   logic [7:0]  a1;

   // pipeline flow
   assign s2_adv         = s2_valid_ff && blk_ready;
   assign s2_load        = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_chan.ready = !s1_valid_ff || s2_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   // format classification, unused code decodes as color only
   always_comb begin
      unique case (variant)
         bcd_pkg::VARIANT_BC2: s1_amode_in = bcd_pkg::AMODE_EXPLICIT;
         bcd_pkg::VARIANT_BC3: s1_amode_in = bcd_pkg::AMODE_INTERP;
         default:              s1_amode_in = bcd_pkg::AMODE_COLOR;
      endcase
   end

   // endpoint expansion and palette sums
   assign c0 = s1_cw_ff[15:0];
   assign c1 = s1_cw_ff[31:16];
   assign a0 = s1_aw_ff[7:0];
   assign a1 = s1_aw_ff[15:8];

   always_comb begin
      s2_e0_in[bcd_pkg::CH_BLUE]  = bcd_pkg::expand5(c0[4:0]);
      s2_e0_in[bcd_pkg::CH_GREEN] = bcd_pkg::expand6(c0[10:5]);
      s2_e0_in[bcd_pkg::CH_RED]   = bcd_pkg::expand5(c0[15:11]);
      s2_e1_in[bcd_pkg::CH_BLUE]  = bcd_pkg::expand5(c1[4:0]);
      s2_e1_in[bcd_pkg::CH_GREEN] = bcd_pkg::expand6(c1[10:5]);
      s2_e1_in[bcd_pkg::CH_RED]   = bcd_pkg::expand5(c1[15:11]);
      s2_four_in = (c0 > c1) || (s1_amode_ff != bcd_pkg::AMODE_COLOR);
      for (int ch = 0; ch < 3; ch++) begin
         if (s2_four_in) begin
            s2_sum2_in[ch] = ({2'b00, s2_e0_in[ch]} << 1) + {2'b00, s2_e1_in[ch]};
            s2_sum3_in[ch] = {2'b00, s2_e0_in[ch]} + ({2'b00, s2_e1_in[ch]} << 1);
         end else begin
            s2_sum2_in[ch] = {2'b00, s2_e0_in[ch]} + {2'b00, s2_e1_in[ch]};
            s2_sum3_in[ch] = '0;
         end
      end
   end

   // weighted alpha sums, sevenths or fifths
   always_comb begin
      s2_agt_in = a0 > a1;
      for (int k = 1; k <= 6; k++) begin
         if (s2_agt_in) begin
            s2_asum_in[k-1] = ({3'b000, a0} * 11'(7 - k)) + ({3'b000, a1} * 11'(k));
         end else if (k <= 4) begin
            s2_asum_in[k-1] = ({3'b000, a0} * 11'(5 - k)) + ({3'b000, a1} * 11'(k));
         end else begin
            s2_asum_in[k-1] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_aw_ff    <= req_chan.alpha_word;
         s1_cw_ff    <= req_chan.color_word;
         s1_amode_ff <= s1_amode_in;
      end
      if (s2_load) begin
         s2_e0_ff    <= s2_e0_in;
         s2_e1_ff    <= s2_e1_in;
         s2_sum2_ff  <= s2_sum2_in;
         s2_sum3_ff  <= s2_sum3_in;
         s2_four_ff  <= s2_four_in;
         s2_a0_ff    <= a0;
         s2_a1_ff    <= a1;
         s2_agt_ff   <= s2_agt_in;
         s2_asum_ff  <= s2_asum_in;
         s2_aw_ff    <= s1_aw_ff;
         s2_cidx_ff  <= s1_cw_ff[63:32];
         s2_amode_ff <= s1_amode_ff;
      end
   end

   // palette divisions and block assembly
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         blk.pal[ch][0] = s2_e0_ff[ch];
         blk.pal[ch][1] = s2_e1_ff[ch];
         if (s2_four_ff) begin
            blk.pal[ch][2] = bcd_pkg::div3(s2_sum2_ff[ch]);
            blk.pal[ch][3] = bcd_pkg::div3(s2_sum3_ff[ch]);
         end else begin
            blk.pal[ch][2] = s2_sum2_ff[ch][8:1];
            blk.pal[ch][3] = 8'h00;
         end
      end
      blk.trans3  = !s2_four_ff;
      blk.apal[0] = s2_a0_ff;
      blk.apal[1] = s2_a1_ff;
      for (int k = 1; k <= 6; k++) begin
         if (s2_agt_ff) begin
            blk.apal[k+1] = bcd_pkg::div7(s2_asum_ff[k-1]);
         end else if (k <= 4) begin
            blk.apal[k+1] = bcd_pkg::div5(s2_asum_ff[k-1]);
         end else if (k == 5) begin
            blk.apal[k+1] = 8'd0;
         end else begin
            blk.apal[k+1] = 8'd255;
         end
      end
      blk.alpha_word = s2_aw_ff;
      blk.cidx       = s2_cidx_ff;
      blk.amode      = s2_amode_ff;
   end

   assign blk_valid = s2_valid_ff;

endmodule

// ===== hdl/bcd_queue.sv =====
// ---------------------------------------------------------------------------
// bcd_queue
// Short block queue that decouples the palette front end from the pixel
// back end.
// ---------------------------------------------------------------------------
`include "bc_block_texture_decoder_core_macros.svh"

module bcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  bcd_pkg::blk_type  in_blk,
   input  logic              in_valid,
   output logic              in_ready,
   output bcd_pkg::blk_type  out_blk,
   output logic              out_valid,
   input  logic              out_pop
);

   bcd_pkg::blk_type                  entry_ff [bcd_pkg::QDEPTH];
   logic [bcd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bcd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bcd_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              push;
   logic                              pop;

   assign in_ready  = cnt_ff != bcd_pkg::QCNT_W'(bcd_pkg::QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_blk   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bcd_pkg::QPTR_W'(bcd_pkg::QDEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bcd_pkg::QPTR_W'(bcd_pkg::QDEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_blk;
      end
   end

   `BCD_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= bcd_pkg::QCNT_W'(bcd_pkg::QDEPTH))
   `BCD_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_ff == $past(cnt_ff) + bcd_pkg::QCNT_W'(1))
   `BCD_ASSERT_NEXT(a_cnt_dec, pop && !push, cnt_ff == $past(cnt_ff) - bcd_pkg::QCNT_W'(1))

endmodule

// ===== hdl/bcd_back.sv =====
// ---------------------------------------------------------------------------
// bcd_back
// Back end: walks the sixteen pixels of the queue head block, one a cycle
// when not stalled, holding each in the result register until it is taken.
// ---------------------------------------------------------------------------
`include "bc_block_texture_decoder_core_macros.svh"

module bcd_back (
   input  logic              clock,
   input  logic              reset,
   input  bcd_pkg::blk_type  q_blk,
   input  logic              q_valid,
   output logic              q_pop,
   bcd_rsp_if.source         rsp_chan
);

   logic [bcd_pkg::PIX_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bcd_pkg::PIX_W-1:0] rsp_index_ff;
   logic [7:0]                rsp_blue_ff;
   logic [7:0]                rsp_green_ff;
   logic [7:0]                rsp_red_ff;
   logic [7:0]                rsp_alpha_ff, rsp_alpha_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      out_load;
   logic [1:0]                ci;
   logic [3:0]                nib;
   logic [5:0]                abit;
   logic [2:0]                ai;

   assign out_load = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_last_in = pix_cnt_ff == bcd_pkg::PIX_W'(bcd_pkg::NUM_PIX - 1);
   assign q_pop    = out_load && rsp_last_in;

   // index extraction for the current pixel
   assign ci   = q_blk.cidx[{pix_cnt_ff, 1'b0} +: 2];
   assign nib  = q_blk.alpha_word[{pix_cnt_ff, 2'b00} +: 4];
   assign abit = bcd_pkg::ALPHA_IDX_BASE + ({2'b00, pix_cnt_ff} * 6'd3);
   assign ai   = q_blk.alpha_word[abit +: 3];

   // alpha selection by format
   always_comb begin
      unique case (q_blk.amode)
         bcd_pkg::AMODE_EXPLICIT: rsp_alpha_in = {nib, nib};
         bcd_pkg::AMODE_INTERP:   rsp_alpha_in = q_blk.apal[ai];
         default: begin
            rsp_alpha_in = (q_blk.trans3 && (ci == bcd_pkg::TRANSPARENT_IDX)) ? 8'd0
                                                                             : 8'd255;
         end
      endcase
   end

   // sequencer and result register control
   always_comb begin
      pix_cnt_in   = pix_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         pix_cnt_in   = pix_cnt_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_cnt_ff   <= pix_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff <= pix_cnt_ff;
         rsp_blue_ff  <= q_blk.pal[bcd_pkg::CH_BLUE][ci];
         rsp_green_ff <= q_blk.pal[bcd_pkg::CH_GREEN][ci];
         rsp_red_ff   <= q_blk.pal[bcd_pkg::CH_RED][ci];
         rsp_alpha_ff <= rsp_alpha_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = rsp_index_ff;
   assign rsp_chan.blue        = rsp_blue_ff;
   assign rsp_chan.green       = rsp_green_ff;
   assign rsp_chan.red         = rsp_red_ff;
   assign rsp_chan.alpha       = rsp_alpha_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

   `BCD_ASSERT_IMPL(a_pix_order, out_load && rsp_valid_ff, pix_cnt_ff == rsp_index_ff + 4'd1)
   `BCD_ASSERT_NEXT(a_pop_last, q_pop, rsp_valid_ff && rsp_last_ff)
   `BCD_ASSERT_IMPL(a_last_index, rsp_valid_ff && rsp_last_ff,
                    rsp_index_ff == bcd_pkg::PIX_W'(bcd_pkg::NUM_PIX - 1))

endmodule

// ===== hdl/bc_block_texture_decoder_core.sv =====
// ---------------------------------------------------------------------------
// bc_block_texture_decoder_core
// BC1/BC2/BC3 4x4 block decoder producing sixteen BGRA8 pixels per block.
// ---------------------------------------------------------------------------
// Each accepted block (alpha word, color word) yields sixteen pixels in row
// order on the result channel, the sixteenth flagged by last_pixel. The pixel
// sequencer in the back end emits one pixel per cycle while the result channel
// is ready; the front end builds palettes in two stages and parks finished
// blocks in a two-entry queue, so new blocks are taken while earlier pixels
// are still going out. A block passes through the capture stage, the sum
// stage, the queue and the result register. The format register (0 BC1,
// 1 BC2, 2 BC3, 3 decodes as BC1) is sampled when a block is accepted; the
// user must write it only while the decoder is idle (the block does not enforce this).
// ---------------------------------------------------------------------------
module bc_block_texture_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   bcd_req_if.sink                          req_chan,
   bcd_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic [1:0]       variant;
   bcd_pkg::blk_type front_blk;
   logic             front_valid;
   logic             front_ready;
   bcd_pkg::blk_type q_blk;
   logic             q_valid;
   logic             q_pop;

   // configuration register
   bcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .variant     (variant)
   );

   // palette front end
   bcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .variant   (variant),
      .blk       (front_blk),
      .blk_valid (front_valid),
      .blk_ready (front_ready)
   );

   // block queue
   bcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_blk    (front_blk),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_blk   (q_blk),
      .out_valid (q_valid),
      .out_pop   (q_pop)
   );

   // pixel back end
   bcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_blk    (q_blk),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Block-level bench for the BC1/BC2/BC3 texture block decoder. A table of
// hand-picked blocks comes first, some with their uniform pixel typed in, then
// randomized blocks under three handshake idling profiles with the format
// register reprogrammed between groups. Every pixel word is checked field by
// field against the typed pixel or an in-bench decode of the block.
// ---------------------------------------------------------------------------
module tb_top;

   // unused format code, decodes like bc1
   localparam logic [1:0] VARIANT_SPARE = 2'd3;
   // register index with nothing behind it
   localparam logic [bcd_pkg::CSR_IDX_W-1:0] REG_UNUSED = 1'b1;

   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int NUM_DIRECTED  = 22;
   localparam int BLOCKS_PER_GROUP = 32;

   typedef struct packed {
      logic [3:0] pixel_index;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       last_pixel;
   } bgra_pixel_type;

   typedef struct packed {
      logic [1:0]  variant;
      logic [63:0] alpha_word;
      logic [63:0] color_word;
      logic        typed;       // all sixteen pixels share the bgra below
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
   } block_row_type;

   logic clock;
   logic reset = 1'b1;
   logic rx_ready = 1'b0;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [bcd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bcd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bcd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   bcd_req_if req_if ();
   bcd_rsp_if rsp_if ();

   assign rsp_if.ready = rx_ready;

   bgra_pixel_type pending_pixels[$];
   bgra_pixel_type head_pixel;
   logic [1:0]     active_variant = bcd_pkg::VARIANT_BC1;
   int             mismatch_count = 0;
   int             stall_cycles = 0;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;

   // hand-picked blocks, grouped by format
   block_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      // bc1 four-color, each index alone: white, black, two thirds, one third
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'h0000_0000_0000_FFFF,
        1'b1, 8'd255, 8'd255, 8'd255, 8'd255},
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'h5555_5555_0000_FFFF,
        1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'hAAAA_AAAA_0000_FFFF,
        1'b1, 8'd170, 8'd170, 8'd170, 8'd255},
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'hFFFF_FFFF_0000_FFFF,
        1'b1, 8'd85, 8'd85, 8'd85, 8'd255},
      // bc1 three-color: transparent black, midpoint; alpha word ignored
      '{bcd_pkg::VARIANT_BC1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000,
        1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
      '{bcd_pkg::VARIANT_BC1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_FFFF_0000,
        1'b1, 8'd127, 8'd127, 8'd127, 8'd255},
      // equal endpoints fall into three-color mode; one four-color block among them
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'h1B1B_E4E4_1234_1234,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{bcd_pkg::VARIANT_BC1, 64'h0123_4567_89AB_CDEF, 64'h9C63_36C9_001F_F800,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{bcd_pkg::VARIANT_BC1, 64'h0, 64'hFFFF_FFFF_0000_0000,
        1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
      // spare code behaves as bc1
      '{VARIANT_SPARE, 64'h0, 64'hFFFF_FFFF_FFFF_0000, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
      '{VARIANT_SPARE, 64'h0, 64'hAAAA_AAAA_0000_FFFF, 1'b1, 8'd170, 8'd170, 8'd170, 8'd255},
      // bc2 forces four-color mode, explicit nibble alpha
      '{bcd_pkg::VARIANT_BC2, 64'h0, 64'hFFFF_FFFF_FFFF_0000,
        1'b1, 8'd170, 8'd170, 8'd170, 8'd0},
      '{bcd_pkg::VARIANT_BC2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_FFFF_0000,
        1'b1, 8'd85, 8'd85, 8'd85, 8'd255},
      '{bcd_pkg::VARIANT_BC2, 64'hFEDC_BA98_7654_3210, 64'hE4E4_1B1B_7BEF_8410,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{bcd_pkg::VARIANT_BC2, 64'h8888_1111_F0F0_0F0F, 64'h2727_D8D8_5A5A_5A5A,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // bc3 palette endpoints, an interpolated seventh and the fixed 0 / 255 entries
      '{bcd_pkg::VARIANT_BC3, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF,
        1'b1, 8'd255, 8'd255, 8'd255, 8'd255},
      '{bcd_pkg::VARIANT_BC3, 64'hFFFF_FFFF_FFFF_FF00, 64'h5555_5555_0000_FFFF,
        1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
      '{bcd_pkg::VARIANT_BC3, 64'hFFFF_FFFF_FFFF_00FF, 64'h5555_5555_0000_FFFF,
        1'b1, 8'd0, 8'd0, 8'd0, 8'd36},
      '{bcd_pkg::VARIANT_BC3, 64'h0000_0000_0000_FF00, 64'hFFFF_FFFF_FFFF_0000,
        1'b1, 8'd170, 8'd170, 8'd170, 8'd0},
      '{bcd_pkg::VARIANT_BC3, 64'hDB6D_B6DB_6DB6_FF00, 64'h0000_0000_0000_FFFF,
        1'b1, 8'd255, 8'd255, 8'd255, 8'd0},
      // eight-entry and equal-endpoint six-entry palettes, mixed indices
      '{bcd_pkg::VARIANT_BC3, 64'hFAC6_8820_5397_64C8, 64'h1E2D_3C4B_F81F_07E0,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{bcd_pkg::VARIANT_BC3, 64'h0123_4567_89AB_4D4D, 64'hB4E1_72C6_07E0_F81F,
        1'b0, 8'd0, 8'd0, 8'd0, 8'd0}
   };

   bc_block_texture_decoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // field compare, counts and reports a mismatch
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // decode one block into sixteen expected pixel words
   function automatic void decode_block(input logic [1:0] variant, input logic [63:0] aw,
                                        input logic [63:0] cw);
      int unsigned    bgr [4][3];
      int unsigned    color_alpha [4];
      int unsigned    apal [8];
      int unsigned    ep, c0, c1, a0, a1, ci;
      logic [3:0]     nib;
      bit             four_color;
      bgra_pixel_type px;
      c0 = 32'(cw[15:0]);
      c1 = 32'(cw[31:16]);
      // rgb565 endpoints widened by replicating the top bits
      for (int e = 0; e < 2; e++) begin
         ep = (e == 0) ? c0 : c1;
         bgr[e][0] = ((ep & 'h1F) << 3) | ((ep & 'h1F) >> 2);
         bgr[e][1] = (((ep >> 5) & 'h3F) << 2) | (((ep >> 5) & 'h3F) >> 4);
         bgr[e][2] = (((ep >> 11) & 'h1F) << 3) | (((ep >> 11) & 'h1F) >> 2);
      end
      four_color = (c0 > c1) || (variant == bcd_pkg::VARIANT_BC2) ||
                   (variant == bcd_pkg::VARIANT_BC3);
      for (int ch = 0; ch < 3; ch++) begin
         if (four_color) begin
            bgr[2][ch] = (2 * bgr[0][ch] + bgr[1][ch]) / 3;
            bgr[3][ch] = (bgr[0][ch] + 2 * bgr[1][ch]) / 3;
         end else begin
            bgr[2][ch] = (bgr[0][ch] + bgr[1][ch]) / 2;
            bgr[3][ch] = 0;
         end
      end
      color_alpha[0] = 255;
      color_alpha[1] = 255;
      color_alpha[2] = 255;
      color_alpha[3] = four_color ? 255 : 0;
      // interpolated alpha palette
      a0 = 32'(aw[7:0]);
      a1 = 32'(aw[15:8]);
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++)
            apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
         for (int k = 1; k <= 4; k++)
            apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end
      for (int i = 0; i < bcd_pkg::NUM_PIX; i++) begin
         ci = 32'(cw[32 + 2 * i +: 2]);
         px.pixel_index = 4'(i);
         px.blue  = 8'(bgr[ci][0]);
         px.green = 8'(bgr[ci][1]);
         px.red   = 8'(bgr[ci][2]);
         px.alpha = 8'(color_alpha[ci]);
         if (variant == bcd_pkg::VARIANT_BC2) begin
            nib = aw[4 * i +: 4];
            px.alpha = {nib, nib};
         end else if (variant == bcd_pkg::VARIANT_BC3) begin
            px.alpha = 8'(apal[aw[16 + 3 * i +: 3]]);
         end
         px.last_pixel = (i == bcd_pkg::NUM_PIX - 1);
         pending_pixels.push_back(px);
      end
   endfunction

   // random block, biased toward equal and extreme endpoints
   function automatic block_row_type random_row();
      block_row_type row;
      row = '0;
      row.alpha_word = {$urandom, $urandom};
      row.color_word = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: row.color_word[31:16] = row.color_word[15:0];
         1: begin
            row.color_word[15:0]  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            row.color_word[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: row.alpha_word[15:8] = row.alpha_word[7:0];
         1: begin
            row.alpha_word[7:0]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            row.alpha_word[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return row;
   endfunction

   // apb write, register takes the value at the access edge
   task automatic csr_write(input logic [bcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == bcd_pkg::REG_BC_VARIANT)
         active_variant = data[1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(input logic [bcd_pkg::CSR_IDX_W-1:0] idx,
                           output logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // set the format with junk in the upper bits, then read it back
   task automatic program_variant(input logic [1:0] variant);
      logic [31:0] wdata;
      logic [31:0] rdata;
      wdata = $urandom;
      wdata[1:0] = variant;
      csr_write(bcd_pkg::REG_BC_VARIANT, wdata);
      // idle gap between the two transfers
      @(posedge clock);
      csr_read(bcd_pkg::REG_BC_VARIANT, rdata);
      check_field("bc_variant", {62'd0, variant}, {32'd0, rdata});
   endtask

   // drop valid and hold off until every pixel word has come back
   task automatic wait_pixels_drained();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one block, record its expected pixels once taken
   task automatic send_block(input block_row_type row);
      bgra_pixel_type px;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.alpha_word <= row.alpha_word;
      req_if.color_word <= row.color_word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (row.typed) begin
         for (int i = 0; i < bcd_pkg::NUM_PIX; i++) begin
            px = {4'(i), row.blue, row.green, row.red, row.alpha,
                  i == bcd_pkg::NUM_PIX - 1};
            pending_pixels.push_back(px);
         end
      end else begin
         decode_block(active_variant, row.alpha_word, row.color_word);
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // compare each pixel word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel word with no block pending: pixel_index %0d", rsp_if.pixel_index);
            mismatch_count++;
         end else begin
            head_pixel = pending_pixels.pop_front();
            check_field("pixel_index", 64'(head_pixel.pixel_index),
                        64'(rsp_if.pixel_index));
            check_field("blue", 64'(head_pixel.blue), 64'(rsp_if.blue));
            check_field("green", 64'(head_pixel.green), 64'(rsp_if.green));
            check_field("red", 64'(head_pixel.red), 64'(rsp_if.red));
            check_field("alpha", 64'(head_pixel.alpha), 64'(rsp_if.alpha));
            check_field("last_pixel", 64'(head_pixel.last_pixel),
                        64'(rsp_if.last_pixel));
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus
   initial begin
      logic [1:0] variant_order [4];
      variant_order = '{bcd_pkg::VARIANT_BC1, bcd_pkg::VARIANT_BC2,
                        bcd_pkg::VARIANT_BC3, VARIANT_SPARE};
      req_if.valid      <= 1'b0;
      req_if.alpha_word <= '0;
      req_if.color_word <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 23;
      rx_idle_pct = 87;
      // write to a missing register must leave the reset format alone
      csr_write(REG_UNUSED, {30'd0, bcd_pkg::VARIANT_BC2});

      // directed table
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (directed_rows[r].variant != active_variant) begin
            wait_pixels_drained();
            program_variant(directed_rows[r].variant);
         end
         send_block(directed_rows[r]);
      end

      // random groups under three idling profiles
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 87 : 0;
         rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 23 : 0;
         for (int grp = 0; grp < 4; grp++) begin
            wait_pixels_drained();
            program_variant(variant_order[(grp + phase) % 4]);
            for (int b = 0; b < BLOCKS_PER_GROUP; b++)
               send_block(random_row());
         end
      end

      wait_pixels_drained();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bcd_pkg.sv
hdl/bcd_req_if.sv
hdl/bcd_rsp_if.sv
hdl/bcd_csr.sv
hdl/bcd_front.sv
hdl/bcd_queue.sv
hdl/bcd_back.sv
hdl/bc_block_texture_decoder_core.sv
test/tb_top.sv
